@@ rtl/core/hbq_pkg.sv @@
// Package for the binary min-heap queue: transaction payload types,
// action and status codes, and the signed key compare.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hbq_pkg;

   localparam int KEY_W = 32;
   localparam int TAG_W = 10;
   localparam int OCC_W = 11;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic                    action;
      logic signed [KEY_W-1:0] item_key;
      logic [TAG_W-1:0]        item_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [TAG_W-1:0]        removed_tag;
      logic signed [KEY_W-1:0] removed_key;
      logic [OCC_W-1:0]        occupancy;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
      return $signed(a) < $signed(b);
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/hbq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/hbq_ctrl.sv @@
// Heap sequencer: walks sift-up and sift-down over the entry RAM, one
// level per read/compare/write round, and builds the response.
// Depends on hbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbq_ctrl #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire hbq_pkg::req_type            req,
   output logic                             idle,
   output logic                             res_valid,
   input  wire logic                        res_ready,
   output hbq_pkg::rsp_type                 res,
   output logic                             mem_we,
   output logic      [$clog2(CAPACITY)-1:0] mem_waddr,
   output hbq_pkg::entry_type               mem_wdata,
   output logic      [$clog2(CAPACITY)-1:0] mem_raddr,
   input  wire hbq_pkg::entry_type          mem_rdata
);

   import hbq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = CW + 1;  // room for twice a slot number
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_UP_CMP  = 9'b000000010,
      S_DN_ROOT = 9'b000000100,
      S_DN_LAST = 9'b000001000,
      S_DN_L    = 9'b000010000,
      S_DN_R    = 9'b000100000,
      S_FIN     = 9'b001000000,
      S_DONE    = 9'b010000000,
      S_SPARE   = 9'b100000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [SW-1:0]   pos_ff, pos_in;
   logic [SW-1:0]   child_ff, child_in;
   entry_type       item_ff, item_in;
   entry_type       left_ff, left_in;
   rsp_type         res_ff, res_in;

   logic [SW-1:0]   n_slots;
   entry_type       chosen;
   logic [SW-1:0]   chosen_slot;
   logic [SW-1:0]   next_child;

   // slot numbers run from 1; RAM addresses from 0
   function automatic logic [AW-1:0] to_addr(input logic [SW-1:0] slot);
      logic [SW-1:0] tmp;
      tmp = slot - SW'(1);
      return tmp[AW-1:0];
   endfunction

   assign n_slots = SW'(count_ff);

   always_comb begin
      if (key_less(mem_rdata.key, left_ff.key)) begin
         chosen      = mem_rdata;
         chosen_slot = child_ff + SW'(1);
      end else begin
         chosen      = left_ff;
         chosen_slot = child_ff;
      end
      next_child = chosen_slot << 1;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      child_in  = child_ff;
      item_in   = item_ff;
      left_in   = left_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = to_addr(pos_ff);
      mem_wdata = item_ff;
      mem_raddr = to_addr(SW'(1));

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               res_in.removed_tag = '0;
               res_in.removed_key = '0;
               res_in.occupancy   = '0;
               if (req.action == ACT_INSERT) begin
                  if (count_ff == FULL_COUNT) begin
                     res_in.status = ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     res_in.status = ST_DONE;
                     item_in.key   = req.item_key;
                     item_in.tag   = req.item_tag;
                     count_in      = count_ff + CW'(1);
                     pos_in        = n_slots + SW'(1);
                     mem_raddr     = to_addr((n_slots + SW'(1)) >> 1);
                     state_in      = (count_ff == '0) ? S_FIN : S_UP_CMP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in.status = ST_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     res_in.status = ST_DONE;
                     count_in      = count_ff - CW'(1);
                     mem_raddr     = to_addr(SW'(1));
                     state_in      = S_DN_ROOT;
                  end
               end
            end
         end

         S_UP_CMP: begin
            if (key_less(item_ff.key, mem_rdata.key)) begin
               // parent moves down into the hole
               mem_we    = 1'b1;
               mem_wdata = mem_rdata;
               pos_in    = pos_ff >> 1;
               mem_raddr = to_addr(pos_ff >> 2);
               if ((pos_ff >> 1) == SW'(1)) begin
                  state_in = S_FIN;
               end
            end else begin
               mem_we   = 1'b1;
               state_in = S_DONE;
            end
         end

         S_DN_ROOT: begin
            res_in.removed_key = mem_rdata.key;
            res_in.removed_tag = mem_rdata.tag;
            mem_raddr          = to_addr(n_slots + SW'(1));
            state_in           = S_DN_LAST;
         end

         S_DN_LAST: begin
            item_in = mem_rdata;
            pos_in  = SW'(1);
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else if (count_ff == CW'(1)) begin
               mem_we    = 1'b1;
               mem_waddr = to_addr(SW'(1));
               mem_wdata = mem_rdata;
               state_in  = S_DONE;
            end else begin
               child_in  = SW'(2);
               mem_raddr = to_addr(SW'(2));
               state_in  = S_DN_L;
            end
         end

         S_DN_L: begin
            left_in = mem_rdata;
            if (child_ff < n_slots) begin
               mem_raddr = to_addr(child_ff + SW'(1));
               state_in  = S_DN_R;
            end else if (key_less(mem_rdata.key, item_ff.key)) begin
               // lone left child moves up; the last level is reached
               mem_we    = 1'b1;
               mem_wdata = mem_rdata;
               pos_in    = child_ff;
               state_in  = S_FIN;
            end else begin
               mem_we   = 1'b1;
               state_in = S_DONE;
            end
         end

         S_DN_R: begin
            if (key_less(chosen.key, item_ff.key)) begin
               mem_we    = 1'b1;
               mem_wdata = chosen;
               pos_in    = chosen_slot;
               if (next_child <= n_slots) begin
                  child_in  = next_child;
                  mem_raddr = to_addr(next_child);
                  state_in  = S_DN_L;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               mem_we   = 1'b1;
               state_in = S_DONE;
            end
         end

         S_FIN: begin
            mem_we   = 1'b1;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff   <= pos_in;
      child_ff <= child_in;
      item_ff  <= item_in;
      left_ff  <= left_in;
      res_ff   <= res_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      res           = res_ff;
      res.occupancy = OCC_W'(count_ff);
   end

endmodule

`default_nettype wire

@@ rtl/core/binary_min_heap_queue_core.sv @@
// Binary min-heap priority queue of (key, tag) pairs.
// req_*: one transaction per operation. action selects insert of
// item_key/item_tag or removal of the smallest key (ties: earliest rule of
// the heap walk). rsp_*: exactly one transaction per request, in order,
// with status, the removed tag and key (zero unless a successful removal)
// and the entry count after the operation.
// One operation is in flight at a time. An insert climbs L levels (at
// most log2 CAPACITY); a removal walks down one level per round, as
// each level needs up to two reads from the single read port of the
// entry RAM plus a compare. Refused operations (insert when full,
// removal when empty) change nothing.
// Responses sit in an output register; the sequencer holds its finished
// result while that register is full and rsp_ready is low, so no request
// is taken until the response can be stored.
// Reset (synchronous, active high) empties the heap at once; the RAM
// contents are not cleared.
// Depends on hbq_pkg, hbq_ctrl, hbq_ram.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue_core #(
   parameter int CAPACITY = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire hbq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output hbq_pkg::rsp_type      rsp_data
);

   import hbq_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic          ctrl_idle;
   logic          res_valid;
   logic          res_ready;
   rsp_type       res;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [AW-1:0] mem_raddr;
   entry_type     mem_rdata;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   assign req_ready = ctrl_idle;
   assign res_ready = !rsp_valid_ff || rsp_ready;

   hbq_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid && ctrl_idle),
      .req      (req_data),
      .idle     (ctrl_idle),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res      (res),
      .mem_we   (mem_we),
      .mem_waddr(mem_waddr),
      .mem_wdata(mem_wdata),
      .mem_raddr(mem_raddr),
      .mem_rdata(mem_rdata)
   );

   hbq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      priority if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ tb/binary_min_heap_queue_core_tb.sv @@
// Self-checking testbench for binary_min_heap_queue_core: a directed table, then random
// insert/remove traffic that fills the heap to capacity and drains it part way, checked
// against a behavioural heap. Depends on hbq_pkg and the core RTL.
`timescale 1ns / 1ps

module binary_min_heap_queue_core_tb;
   import hbq_pkg::*;

   localparam int CAPACITY    = 1024;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 40;
   localparam int DRAIN_OPS   = 680;
   localparam int CALM_OPS    = 120;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   binary_min_heap_queue_core #(.CAPACITY(CAPACITY)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // behavioural heap, slots 1..heap_count
   logic signed [KEY_W-1:0] heap_key [0:CAPACITY];
   logic [TAG_W-1:0]        heap_tag [0:CAPACITY];
   int unsigned             heap_count;

   rsp_type expected_rsp [$];
   int      mismatch_count;
   int      cycle_count;
   bit      allow_idle;
   int      quiet_left;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   dir_row_type dir_rows [$];

   function automatic req_type mk_req(input logic act, input logic signed [KEY_W-1:0] key,
                                      input logic [TAG_W-1:0] tag);
      req_type r;
      r.action   = act;
      r.item_key = key;
      r.item_tag = tag;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input logic [1:0] st, input logic [TAG_W-1:0] tag,
                                      input logic signed [KEY_W-1:0] key,
                                      input logic [OCC_W-1:0] occ);
      rsp_type r;
      r.status      = st;
      r.removed_tag = tag;
      r.removed_key = key;
      r.occupancy   = occ;
      return r;
   endfunction

   // apply one operation to the behavioural heap and return the response it gives
   function automatic rsp_type predict_heap_op(input req_type r);
      rsp_type                 res;
      int unsigned             pos;
      int unsigned             hole;
      int unsigned             child;
      logic signed [KEY_W-1:0] last_key;
      logic [TAG_W-1:0]        last_tag;
      bit                      walking;
      res = mk_rsp(ST_DONE, '0, '0, '0);
      if (r.action == ACT_INSERT) begin
         if (heap_count >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            heap_count = heap_count + 1;
            pos        = heap_count;
            while (pos != 1 && $signed(r.item_key) < $signed(heap_key[pos/2])) begin
               heap_key[pos] = heap_key[pos/2];
               heap_tag[pos] = heap_tag[pos/2];
               pos           = pos / 2;
            end
            heap_key[pos] = r.item_key;
            heap_tag[pos] = r.item_tag;
         end
      end else begin
         if (heap_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            last_key        = heap_key[heap_count];
            last_tag        = heap_tag[heap_count];
            res.removed_key = heap_key[1];
            res.removed_tag = heap_tag[1];
            heap_count      = heap_count - 1;
            hole            = 1;
            child           = 2;
            walking         = 1'b1;
            while (walking && child <= heap_count) begin
               // right child only when strictly smaller; stop on equal
               if (child < heap_count && $signed(heap_key[child+1]) < $signed(heap_key[child]))
                  child = child + 1;
               if (!($signed(heap_key[child]) < $signed(last_key))) begin
                  walking = 1'b0;
               end else begin
                  heap_key[hole] = heap_key[child];
                  heap_tag[hole] = heap_tag[child];
                  hole           = child;
                  child          = child * 2;
               end
            end
            heap_key[hole] = last_key;
            heap_tag[hole] = last_tag;
         end
      end
      res.occupancy = heap_count[OCC_W-1:0];
      return res;
   endfunction

   function automatic bit calm();
      return !allow_idle || quiet_left > 0;
   endfunction

   // keys biased towards extremes and a narrow band, so ties are common
   function automatic logic signed [KEY_W-1:0] rand_key();
      logic signed [KEY_W-1:0] k;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: k = 32'sh8000_0000;
               1: k = 32'sh7FFF_FFFF;
               2: k = '0;
               default: k = -32'sd1;
            endcase
         end
         1, 2, 3: k = $signed($urandom_range(0, 16)) - 32'sd8;
         default: k = $urandom;
      endcase
      return k;
   endfunction

   task automatic send_op(input req_type r, input bit typed, input rsp_type want);
      rsp_type pred;
      if (quiet_left > 0)
         quiet_left = quiet_left - 1;
      else if ($urandom_range(0, 39) == 0)
         quiet_left = $urandom_range(20, 60);
      if (!calm() && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = predict_heap_op(r);
      expected_rsp.push_back(typed ? want : pred);
   endtask

   task automatic send_random(input logic act);
      send_op(mk_req(act, rand_key(), TAG_W'($urandom_range(0, 1023))), 1'b0, '0);
   endtask

   initial begin
      dir_rows.push_back('{mk_req(ACT_REMOVE, 32'sh0, 10'h0), 1'b1,
                           mk_rsp(ST_EMPTY, 10'h0, 32'sh0, 11'd0)});
      dir_rows.push_back('{mk_req(ACT_INSERT, 32'sh7FFF_FFFF, 10'h3FF), 1'b1,
                           mk_rsp(ST_DONE, 10'h0, 32'sh0, 11'd1)});
      dir_rows.push_back('{mk_req(ACT_INSERT, 32'sh8000_0000, 10'h000), 1'b1,
                           mk_rsp(ST_DONE, 10'h0, 32'sh0, 11'd2)});
      dir_rows.push_back('{mk_req(ACT_INSERT, 32'sd5, 10'h155), 1'b1,
                           mk_rsp(ST_DONE, 10'h0, 32'sh0, 11'd3)});
      dir_rows.push_back('{mk_req(ACT_INSERT, 32'sd5, 10'h2AA), 1'b1,
                           mk_rsp(ST_DONE, 10'h0, 32'sh0, 11'd4)});
      dir_rows.push_back('{mk_req(ACT_INSERT, -32'sd1, 10'h007), 1'b1,
                           mk_rsp(ST_DONE, 10'h0, 32'sh0, 11'd5)});
      dir_rows.push_back('{mk_req(ACT_REMOVE, 32'sh1234_5678, 10'h2AA), 1'b1,
                           mk_rsp(ST_DONE, 10'h000, 32'sh8000_0000, 11'd4)});
      dir_rows.push_back('{mk_req(ACT_REMOVE, 32'sh0, 10'h0), 1'b1,
                           mk_rsp(ST_DONE, 10'h007, -32'sd1, 11'd3)});
      // equal keys: which tag leaves first follows the heap walk
      dir_rows.push_back('{mk_req(ACT_REMOVE, 32'sh0, 10'h0), 1'b0, '0});
      dir_rows.push_back('{mk_req(ACT_REMOVE, 32'sh0, 10'h0), 1'b0, '0});
      // last entry out
      dir_rows.push_back('{mk_req(ACT_REMOVE, 32'sh0, 10'h0), 1'b1,
                           mk_rsp(ST_DONE, 10'h3FF, 32'sh7FFF_FFFF, 11'd0)});
      dir_rows.push_back('{mk_req(ACT_REMOVE, -32'sd1, 10'h3FF), 1'b1,
                           mk_rsp(ST_EMPTY, 10'h0, 32'sh0, 11'd0)});
      for (int i = 1; i <= 4; i++)
         dir_rows.push_back('{mk_req(ACT_INSERT, 32'sd3, TAG_W'(i)), 1'b0, '0});
      dir_rows.push_back('{mk_req(ACT_INSERT, 32'sd1, 10'h005), 1'b0, '0});
      dir_rows.push_back('{mk_req(ACT_INSERT, 32'sd0, 10'h3FF), 1'b0, '0});
      for (int i = 0; i < 3; i++)
         dir_rows.push_back('{mk_req(ACT_REMOVE, 32'sh0, 10'h0), 1'b0, '0});
      dir_rows.push_back('{mk_req(ACT_INSERT, 32'sh8000_0000, 10'h200), 1'b0, '0});
      dir_rows.push_back('{mk_req(ACT_REMOVE, 32'sh0, 10'h0), 1'b0, '0});
      dir_rows.push_back('{mk_req(ACT_REMOVE, 32'sh0, 10'h0), 1'b0, '0});
   end

   // stimulus
   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data       <= '0;
      heap_count     = 0;
      mismatch_count = 0;
      allow_idle     = 1'b1;
      quiet_left     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_op(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

      // mixed traffic around a small heap
      repeat (120)
         send_random(($urandom_range(0, 9) < 4) ? ACT_REMOVE : ACT_INSERT);

      // fill to capacity, then knock on the full heap
      while (heap_count < CAPACITY)
         send_random(($urandom_range(0, 19) == 0) ? ACT_REMOVE : ACT_INSERT);
      repeat (6)
         send_random(ACT_INSERT);
      send_random(ACT_REMOVE);
      send_random(ACT_INSERT);
      send_random(ACT_INSERT);

      // drain part way; no idling over the last stretch
      for (int i = 0; i < DRAIN_OPS; i++) begin
         if (i >= DRAIN_OPS - CALM_OPS)
            allow_idle = 1'b0;
         send_random(($urandom_range(0, 99) < 8) ? ACT_INSERT : ACT_REMOVE);
      end
      repeat (3)
         send_random(ACT_REMOVE);
      req_valid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // response back-pressure
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!calm() && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // response check, one transaction per edge
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected response transaction: %h", rsp_data);
            mismatch_count = mismatch_count + 1;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_data.removed_tag !== want.removed_tag) begin
               $error("removed_tag: expected %0d, got %0d", want.removed_tag,
                      rsp_data.removed_tag);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_data.removed_key !== want.removed_key) begin
               $error("removed_key: expected %0d, got %0d", want.removed_key,
                      rsp_data.removed_key);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_data.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_data.occupancy);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count = cycle_count + 1;
         if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                   expected_rsp.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

endmodule

@@ binary_min_heap_queue_core.f @@
rtl/core/hbq_pkg.sv
rtl/core/hbq_ram.sv
rtl/core/hbq_ctrl.sv
rtl/core/binary_min_heap_queue_core.sv
tb/binary_min_heap_queue_core_tb.sv
